@@ rtl/tdi_pkg.sv @@
// Shared types and constants for the thermal dissipation integral block.
// No dependencies.
`default_nettype none
package tdi_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int ACC_WIDTH_DEF   = 64;

	localparam int SPACING_W = 31;
	localparam int DEN_W     = 2 * SPACING_W;
	localparam int QUO_W     = 64;
	localparam int OPND_W    = 64;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int OUT_W     = 32;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_VOLUME = 2'd2;

	localparam logic [SPACING_W-1:0] ONE_Q28 = 31'h1000_0000;

	localparam int TERM_W    = 3;
	localparam int NUM_TERMS = 6;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_SQ      = 3'd0;
	localparam logic [OP_W-1:0] OP_DEN     = 3'd1;
	localparam logic [OP_W-1:0] OP_VOL1    = 3'd2;
	localparam logic [OP_W-1:0] OP_VOL2    = 3'd3;
	localparam logic [OP_W-1:0] OP_CONTRIB = 3'd4;
	localparam logic [OP_W-1:0] OP_RESULT  = 3'd5;

	typedef struct packed {
		logic              load;
		logic              mul_start;
		logic [OP_W-1:0]   mul_op;
		logic              div_start;
		logic [TERM_W-1:0] term;
	} tdi_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} tdi_status_t;

endpackage
`default_nettype wire

@@ rtl/tdi_mul.sv @@
// Multi-cycle 64x64 multiplier, 16 bits of b per cycle.
// Depends on tdi_pkg.
`default_nettype none
module tdi_mul
	import tdi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [OPND_W-1:0] a,
	input  wire logic [OPND_W-1:0] b,
	output logic                   done,
	output logic [PROD_W-1:0]      product
);

	logic [OPND_W-1:0] a_q;
	logic [OPND_W-1:0] b_q;
	logic [PROD_W-1:0] acc_q;
	logic [1:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [OPND_W+15:0] pp;

	assign pp = (OPND_W+16)'(a_q) * (OPND_W+16)'(b_q[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (PROD_W'(pp) << {step_q, 4'b0000});
			b_q   <= b_q >> 16;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

@@ rtl/tdi_div.sv @@
// Restoring bit-serial divider, 64 quotient bits, saturating quotient.
// Depends on tdi_pkg.
`default_nettype none
module tdi_div
	import tdi_pkg::*;
#(
	parameter int NUM_W = 96
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [QUO_W-1:0]      quo
);

	localparam int HI_W = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] quo_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ovf;
	logic [DEN_W:0]   trial;
	logic             take;

	assign ovf   = CMP_W'(num[NUM_W-1:QUO_W]) >= CMP_W'(den);
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign take  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			low_q <= num[QUO_W-1:0];
			rem_q <= DEN_W'(num[NUM_W-1:QUO_W]);
			quo_q <= ovf ? {QUO_W{1'b1}} : '0;
		end else if (busy_q) begin
			low_q <= low_q << 1;
			rem_q <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/tdi_datapath.sv @@
// Datapath: input and config registers, shared multiplier and divider, accumulator.
// Depends on tdi_pkg, tdi_mul, tdi_div.
`default_nettype none
module tdi_datapath
	import tdi_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tdi_cmd_t                      cmd,
	output tdi_status_t                        status,
	input  wire logic                          cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [SPACING_W-1:0]          cfg_data,
	input  wire logic signed [VALUE_WIDTH-1:0] center_value,
	input  wire logic signed [VALUE_WIDTH-1:0] x_minus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] x_plus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] y_minus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] y_plus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] z_minus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] z_plus_value,
	input  wire logic [SPACING_W-1:0]          face_spacing,
	input  wire logic [SPACING_W-1:0]          center_spacing_low,
	input  wire logic [SPACING_W-1:0]          center_spacing_high,
	input  wire logic [1:0]                    x_edge,
	output logic signed [OUT_W-1:0]            nusselt_value
);

	localparam int SQ_W   = 2 * VALUE_WIDTH;
	localparam int NUM_W0 = SQ_W + 32;
	localparam int NUM_W  = (NUM_W0 > 96) ? NUM_W0 : 96;

	logic [SPACING_W-1:0] dy_q, dz_q, inv_q;
	logic [ACC_WIDTH-1:0] sum_q;

	logic signed [VALUE_WIDTH-1:0] c_q;
	logic signed [VALUE_WIDTH-1:0] nb_q [NUM_TERMS];
	logic [SPACING_W-1:0] wf_q, cl_q, ch_q;
	logic [1:0]           edge_q;
	logic [SQ_W-1:0]      sq_q;
	logic [DEN_W-1:0]     den_q;
	logic [QUO_W-1:0]     local_q;
	logic [QUO_W-1:0]     vol_q;
	logic [OUT_W-2:0]     result_q;

	logic signed [VALUE_WIDTH-1:0] nb;
	logic signed [VALUE_WIDTH:0]   diff;
	logic [VALUE_WIDTH-1:0]        mag;
	logic [SPACING_W-1:0]          s1, s2;
	logic                          full;
	logic [OPND_W-1:0]             mul_a, mul_b;
	logic                          mul_done, div_done;
	logic [PROD_W-1:0]             prod;
	logic [QUO_W-1:0]              quo;
	logic [NUM_W-1:0]              num_full, num;
	logic [QUO_W-1:0]              shr28;
	logic [QUO_W:0]                local_sum;
	logic [QUO_W:0]                acc_sum;
	logic                          acc_sat;

	always_comb begin
		nb   = nb_q[0];
		s1   = cl_q;
		s2   = wf_q;
		full = 1'b0;
		case (cmd.term)
			3'd0: begin
				nb = nb_q[0]; s1 = cl_q; s2 = wf_q; full = edge_q[0];
			end
			3'd1: begin
				nb = nb_q[1]; s1 = ch_q; s2 = wf_q; full = edge_q[1];
			end
			3'd2: begin
				nb = nb_q[2]; s1 = dy_q; s2 = dy_q;
			end
			3'd3: begin
				nb = nb_q[3]; s1 = dy_q; s2 = dy_q;
			end
			3'd4: begin
				nb = nb_q[4]; s1 = dz_q; s2 = dz_q;
			end
			3'd5: begin
				nb = nb_q[5]; s1 = dz_q; s2 = dz_q;
			end
			default: begin
				nb = nb_q[0];
			end
		endcase
	end

	assign diff = {c_q[VALUE_WIDTH-1], c_q} - {nb[VALUE_WIDTH-1], nb};
	assign mag  = diff[VALUE_WIDTH] ? VALUE_WIDTH'(-diff) : VALUE_WIDTH'(diff);

	always_comb begin
		mul_a = OPND_W'(mag);
		mul_b = OPND_W'(mag);
		case (cmd.mul_op)
			OP_SQ: begin
				mul_a = OPND_W'(mag);     mul_b = OPND_W'(mag);
			end
			OP_DEN: begin
				mul_a = OPND_W'(s1);      mul_b = OPND_W'(s2);
			end
			OP_VOL1: begin
				mul_a = OPND_W'(wf_q);    mul_b = OPND_W'(dy_q);
			end
			OP_VOL2: begin
				mul_a = vol_q;            mul_b = OPND_W'(dz_q);
			end
			OP_CONTRIB: begin
				mul_a = local_q;          mul_b = vol_q;
			end
			OP_RESULT: begin
				mul_a = OPND_W'(sum_q);   mul_b = OPND_W'(inv_q);
			end
			default: begin
				mul_a = '0;               mul_b = '0;
			end
		endcase
	end

	tdi_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	assign num_full = NUM_W'({sq_q, 32'h0});
	assign num      = full ? num_full : (num_full >> 1);

	tdi_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign shr28     = (|prod[PROD_W-1:92]) ? {QUO_W{1'b1}} : prod[91:28];
	assign local_sum = {1'b0, local_q} + {1'b0, quo};
	assign acc_sum   = {1'b0, QUO_W'(sum_q)} + {1'b0, shr28};
	assign acc_sat   = acc_sum > (QUO_W+1)'({ACC_WIDTH{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dy_q  <= ONE_Q28;
			dz_q  <= ONE_Q28;
			inv_q <= ONE_Q28;
			sum_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SPACING_Y:      dy_q  <= cfg_data;
					CFG_SPACING_Z:      dz_q  <= cfg_data;
					CFG_INVERSE_VOLUME: inv_q <= cfg_data;
					default: ;
				endcase
			end
			if (mul_done && cmd.mul_op == OP_CONTRIB) begin
				sum_q <= acc_sat ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];
			end else if (mul_done && cmd.mul_op == OP_RESULT) begin
				sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q     <= center_value;
			nb_q[0] <= x_minus_value;
			nb_q[1] <= x_plus_value;
			nb_q[2] <= y_minus_value;
			nb_q[3] <= y_plus_value;
			nb_q[4] <= z_minus_value;
			nb_q[5] <= z_plus_value;
			wf_q    <= face_spacing;
			cl_q    <= center_spacing_low;
			ch_q    <= center_spacing_high;
			edge_q  <= x_edge;
			local_q <= '0;
		end else if (div_done) begin
			local_q <= local_sum[QUO_W] ? {QUO_W{1'b1}} : local_sum[QUO_W-1:0];
		end
		if (mul_done) begin
			case (cmd.mul_op)
				OP_SQ:   sq_q  <= prod[SQ_W-1:0];
				OP_DEN:  den_q <= prod[DEN_W-1:0];
				OP_VOL1: vol_q <= shr28;
				OP_VOL2: vol_q <= shr28;
				OP_RESULT: result_q <= (|prod[PROD_W-1:67]) ? {(OUT_W-1){1'b1}}
					: prod[66:36];
				default: ;
			endcase
		end
	end

	assign status.mul_done = mul_done;
	assign status.div_done = div_done;
	assign nusselt_value   = {1'b0, result_q};

endmodule
`default_nettype wire

@@ rtl/tdi_ctrl.sv @@
// Controller: sequences the six stencil terms, volume scaling and the result.
// Depends on tdi_pkg.
`default_nettype none
module tdi_ctrl
	import tdi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        last_cell,
	output logic             out_valid,
	input  wire logic        out_ready,
	output tdi_cmd_t         cmd,
	input  wire tdi_status_t status
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SQ_GO    = 4'd1;
	localparam logic [3:0] S_SQ_WAIT  = 4'd2;
	localparam logic [3:0] S_DEN_GO   = 4'd3;
	localparam logic [3:0] S_DEN_WAIT = 4'd4;
	localparam logic [3:0] S_DIV_GO   = 4'd5;
	localparam logic [3:0] S_DIV_WAIT = 4'd6;
	localparam logic [3:0] S_V1_GO    = 4'd7;
	localparam logic [3:0] S_V1_WAIT  = 4'd8;
	localparam logic [3:0] S_V2_GO    = 4'd9;
	localparam logic [3:0] S_V2_WAIT  = 4'd10;
	localparam logic [3:0] S_CON_GO   = 4'd11;
	localparam logic [3:0] S_CON_WAIT = 4'd12;
	localparam logic [3:0] S_RES_GO   = 4'd13;
	localparam logic [3:0] S_RES_WAIT = 4'd14;

	logic [3:0]        state_q;
	logic [TERM_W-1:0] term_q;
	logic              last_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load      = in_valid && in_ready;
		cmd.mul_start = 1'b0;
		cmd.div_start = 1'b0;
		cmd.term      = term_q;
		cmd.mul_op    = OP_SQ;
		case (state_q)
			S_SQ_GO:    begin cmd.mul_op = OP_SQ;      cmd.mul_start = 1'b1; end
			S_SQ_WAIT:  cmd.mul_op = OP_SQ;
			S_DEN_GO:   begin cmd.mul_op = OP_DEN;     cmd.mul_start = 1'b1; end
			S_DEN_WAIT: cmd.mul_op = OP_DEN;
			S_DIV_GO:   cmd.div_start = 1'b1;
			S_V1_GO:    begin cmd.mul_op = OP_VOL1;    cmd.mul_start = 1'b1; end
			S_V1_WAIT:  cmd.mul_op = OP_VOL1;
			S_V2_GO:    begin cmd.mul_op = OP_VOL2;    cmd.mul_start = 1'b1; end
			S_V2_WAIT:  cmd.mul_op = OP_VOL2;
			S_CON_GO:   begin cmd.mul_op = OP_CONTRIB; cmd.mul_start = 1'b1; end
			S_CON_WAIT: cmd.mul_op = OP_CONTRIB;
			S_RES_GO: begin
				cmd.mul_op    = OP_RESULT;
				cmd.mul_start = !out_valid_q;
			end
			S_RES_WAIT: cmd.mul_op = OP_RESULT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						term_q  <= '0;
						last_q  <= last_cell;
						state_q <= S_SQ_GO;
					end
				end
				S_SQ_GO:   state_q <= S_SQ_WAIT;
				S_SQ_WAIT: if (status.mul_done) state_q <= S_DEN_GO;
				S_DEN_GO:  state_q <= S_DEN_WAIT;
				S_DEN_WAIT: if (status.mul_done) state_q <= S_DIV_GO;
				S_DIV_GO:  state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (status.div_done) begin
						if (term_q == TERM_W'(NUM_TERMS - 1)) begin
							state_q <= S_V1_GO;
						end else begin
							term_q  <= term_q + 1'b1;
							state_q <= S_SQ_GO;
						end
					end
				end
				S_V1_GO:   state_q <= S_V1_WAIT;
				S_V1_WAIT: if (status.mul_done) state_q <= S_V2_GO;
				S_V2_GO:   state_q <= S_V2_WAIT;
				S_V2_WAIT: if (status.mul_done) state_q <= S_CON_GO;
				S_CON_GO:  state_q <= S_CON_WAIT;
				S_CON_WAIT: begin
					if (status.mul_done) begin
						state_q <= last_q ? S_RES_GO : S_IDLE;
					end
				end
				S_RES_GO: if (!out_valid_q) state_q <= S_RES_WAIT;
				S_RES_WAIT: begin
					if (status.mul_done) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/thermal_dissipation_integral.sv @@
// Top level of the thermal dissipation integral: controller plus datapath.
// Depends on tdi_pkg, tdi_ctrl, tdi_datapath.
//
//   channel | handshake              | payload
//   in      | in_valid / in_ready    | seven temperatures, spacings, x_edge, last_cell
//   out     | out_valid / out_ready  | nusselt_value
//   cfg     | cfg_wr_en              | cfg_index, cfg_data
//
// in_ready returns only once a request is done, so requests do not overlap:
// six terms (square, spacing product, 64-step divide unless it saturates), then
// three multiplies for volume and contribution. A last cell adds a result
// multiply, after which out_valid rises.
// Reset clears the accumulator and loads all three registers with 1.0.
// A pending result holds the next final multiply, and in_ready stays low meanwhile.
`default_nettype none
module thermal_dissipation_integral
	import tdi_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [SPACING_W-1:0]          cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [VALUE_WIDTH-1:0] center_value,
	input  wire logic signed [VALUE_WIDTH-1:0] x_minus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] x_plus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] y_minus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] y_plus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] z_minus_value,
	input  wire logic signed [VALUE_WIDTH-1:0] z_plus_value,
	input  wire logic [SPACING_W-1:0]          face_spacing,
	input  wire logic [SPACING_W-1:0]          center_spacing_low,
	input  wire logic [SPACING_W-1:0]          center_spacing_high,
	input  wire logic [1:0]                    x_edge,
	input  wire logic                          last_cell,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [OUT_W-1:0]            nusselt_value
);

	tdi_cmd_t    cmd;
	tdi_status_t status;

	tdi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_cell (last_cell),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	tdi_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.ACC_WIDTH   (ACC_WIDTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.center_value        (center_value),
		.x_minus_value       (x_minus_value),
		.x_plus_value        (x_plus_value),
		.y_minus_value       (y_minus_value),
		.y_plus_value        (y_plus_value),
		.z_minus_value       (z_minus_value),
		.z_plus_value        (z_plus_value),
		.face_spacing        (face_spacing),
		.center_spacing_low  (center_spacing_low),
		.center_spacing_high (center_spacing_high),
		.x_edge              (x_edge),
		.nusselt_value       (nusselt_value)
	);

endmodule
`default_nettype wire
